// ===== rtl/core/bitmap_boundary_tracer_macros.svh =====
// Assertion macros for the bitmap boundary tracer.
// Included by the top level; needs a clock named i_clk and a reset named i_rst_n.
`ifndef BITMAP_BOUNDARY_TRACER_MACROS_SVH
`define BITMAP_BOUNDARY_TRACER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define BBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap_boundary_tracer assertion failed");
// Next-cycle implication, checked out of reset.
`define BBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap_boundary_tracer assertion failed");
`else
`define BBT_ASSERT_IMP(lbl, ante, cons)
`define BBT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/bbt_pkg.sv =====
// Shared types and constants of the bitmap boundary tracer.
// No dependencies; imported by the top level.
`default_nettype none

package bbt_pkg;

    localparam int REG_W  = 9;   // scan width / height register width
    localparam int DS_W   = 4;   // downsample register width
    localparam int LPW    = 18;  // linear load position
    localparam int SPW    = 19;  // linear scan position over the padded frame
    localparam int DIVW   = 20;  // divider dividend / quotient
    localparam int DVW    = 10;  // divider divisor / remainder
    localparam int DCW    = 5;   // divider step counter
    localparam int SUB_W  = 3;   // position inside a downsample block
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWNSAMPLE  = 2'd2;

    localparam logic [REG_W-1:0] SCAN_DIM_RST = 9'd256;
    localparam logic [DS_W-1:0]  DS_RST       = 4'd1;
    localparam logic [DS_W-1:0]  DS_MAX       = 4'd8;

    localparam logic [2:0] PHASE_TURN = 3'd5;
    localparam logic [3:0] MISS_LIMIT = 4'd8;

    // Clockwise neighbour offsets starting at the upper-left.
    localparam logic signed [1:0] STEP_DX [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd1,
                                                  2'sd1, 2'sd0, -2'sd1, -2'sd1};
    localparam logic signed [1:0] STEP_DY [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0,
                                                  2'sd1, 2'sd1, 2'sd1, 2'sd0};

    typedef struct packed {
        logic mode;
        logic pixel_on;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic       new_contour;
        logic       finished;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/bbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the cell and visited maps of the tracer.
`default_nettype none

module bbt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_boundary_tracer.sv =====
// Bitmap boundary tracer: top level, control and map memories.
// Depends on bbt_pkg, bbt_ram and bitmap_boundary_tracer_macros.svh.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready / i_in_data): mode 0 loads one
//    thresholded pixel in raster order, mode 1 requests the next boundary cell.
//  - Output channel (o_out_valid / i_out_ready / o_out_data): one beat per
//    request; a load gives none. A result waits in the output register while
//    the next beat is taken on the input side.
//  - Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//    always ready; write only while the block is idle.
//  - A load beat is taken in S_IDLE, except the first pixel of an image: it
//    clears both maps in S_CLEAR, one entry per cycle over all 2**(XW+YW)
//    entries (65536 at the default 256 by 256), then S_LPIX writes a set pixel.
//  - A request reads and then evaluates each neighbour probe and each scanned
//    frame cell, as the map RAM read port is registered, then S_PUT loads the
//    output register. Up to nine probes per trace step; a scan may run the frame.
//  - After a config write the next beat waits while one shared restoring
//    divider recomputes grid size and positions.
//  - Reset runs the same clearing pass and recompute before the first beat.
//  - A stalled receiver holds the result; further requests wait behind it.
`default_nettype none

`include "bitmap_boundary_tracer_macros.svh"

module bitmap_boundary_tracer #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  bbt_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output bbt_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bbt_pkg::REG_W-1:0]          i_cfg_data
);

    import bbt_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 2 ** AW;
    localparam int GXW   = $clog2(MAX_WIDTH + 1);
    localparam int GYW   = $clog2(MAX_HEIGHT + 1);
    localparam int PXW   = $clog2(MAX_WIDTH + 2);
    localparam int PYW   = $clog2(MAX_HEIGHT + 2);
    localparam int CXW   = PXW + 1;
    localparam int CYW   = PYW + 1;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_LPIX  = 11'b00000000010,
        S_RSYNC = 11'b00000000100,
        S_DIV   = 11'b00000001000,
        S_IDLE  = 11'b00000010000,
        S_T_RD  = 11'b00000100000,
        S_T_EV  = 11'b00001000000,
        S_S_ADV = 11'b00010000000,
        S_S_EV  = 11'b00100000000,
        S_PUT   = 11'b01000000000,
        S_SPARE = 11'b10000000000
    } t_state;

    typedef enum logic [6:0] {
        RS_GW   = 7'b0000001,
        RS_GH   = 7'b0000010,
        RS_MUL  = 7'b0000100,
        RS_LOAD = 7'b0001000,
        RS_BY   = 7'b0010000,
        RS_BX   = 7'b0100000,
        RS_SCAN = 7'b1000000
    } t_rs;

    // control
    t_state r_state, n_state;
    t_rs    r_rs, n_rs;
    logic   r_dirty, n_dirty;
    logic   r_pend, n_pend;
    logic [AW-1:0] r_clr, n_clr;

    // registers
    logic [REG_W-1:0] r_scan_width, n_scan_width;
    logic [REG_W-1:0] r_scan_height, n_scan_height;
    logic [DS_W-1:0]  r_downsample, n_downsample;

    // derived geometry
    logic [GXW-1:0] r_gw, n_gw;
    logic [GYW-1:0] r_gh, n_gh;
    logic [LPW-1:0] r_total, n_total;
    logic [SPW-1:0] r_frame, n_frame;

    // load position
    logic [LPW-1:0]   r_load_pos, n_load_pos;
    logic [REG_W-1:0] r_lx, n_lx, r_ly, n_ly;
    logic [XW-1:0]    r_bx, n_bx;
    logic [YW-1:0]    r_by, n_by;
    logic [SUB_W-1:0] r_subx, n_subx, r_suby, n_suby;

    // walk and trace
    logic           r_pre, n_pre;
    logic [SPW-1:0] r_scan_lin, n_scan_lin;
    logic [PXW-1:0] r_sx, n_sx;
    logic [PYW-1:0] r_sy, n_sy;
    logic           r_inside, n_inside;
    logic           r_tracing, n_tracing;
    logic [XW-1:0]  r_cur_x, n_cur_x, r_start_x, n_start_x;
    logic [YW-1:0]  r_cur_y, n_cur_y, r_start_y, n_start_y;
    logic [2:0]     r_phase, n_phase;
    logic [3:0]     r_miss, n_miss;
    logic signed [CXW-1:0] r_px, n_px;
    logic signed [CYW-1:0] r_py, n_py;

    // divider
    logic [DIVW-1:0] r_dv_num, n_dv_num;
    logic [DVW-1:0]  r_dv_rem, n_dv_rem;
    logic [DVW-1:0]  r_dv_den, n_dv_den;
    logic [DCW-1:0]  r_dv_cnt, n_dv_cnt;

    // output
    logic      r_ov, n_ov;
    t_out_item r_out, n_out;
    t_out_item r_res, n_res;

    // combinational helpers
    logic [REG_W-1:0] eff_w, eff_h;
    logic [DS_W-1:0]  eff_d;
    logic [DVW-1:0]   pw, ph;
    logic             acc_in, acc_cfg;
    logic             load_zero_fix;
    logic             scan_go;
    logic [PXW-1:0]   nxt_sx;
    logic [PYW-1:0]   nxt_sy;
    logic signed [CXW-1:0] sc_x, nb_x, gw_s;
    logic signed [CYW-1:0] sc_y, nb_y, gh_s;
    logic             pr_in_grid, pr_in_mem, pr_start;
    logic [DVW:0]     dv_trial;
    logic             dv_ge;
    logic [DVW-1:0]   dv_rem_next;
    logic [DIVW-1:0]  dv_q_next;

    // memory ports
    logic          cell_we, cell_wdata, cell_q;
    logic [AW-1:0] cell_waddr;
    logic          vis_we, vis_wdata, vis_q;
    logic [AW-1:0] vis_waddr, rd_addr;

    bbt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_raddr (rd_addr),
        .o_rdata (cell_q)
    );

    bbt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (rd_addr),
        .o_rdata (vis_q)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_dirty;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign acc_in      = i_in_valid && o_in_ready;
    assign acc_cfg     = i_cfg_valid;

    // Clamp the registers into their working ranges.
    always_comb begin
        if (r_scan_width == '0) begin
            eff_w = REG_W'(1);
        end else if (32'(r_scan_width) > MAX_WIDTH) begin
            eff_w = REG_W'(MAX_WIDTH);
        end else begin
            eff_w = r_scan_width;
        end
        if (r_scan_height == '0) begin
            eff_h = REG_W'(1);
        end else if (32'(r_scan_height) > MAX_HEIGHT) begin
            eff_h = REG_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_scan_height;
        end
        if (r_downsample == '0) begin
            eff_d = DS_W'(1);
        end else if (r_downsample > DS_MAX) begin
            eff_d = DS_MAX;
        end else begin
            eff_d = r_downsample;
        end
    end

    assign pw   = DVW'(r_gw) + DVW'(2);
    assign ph   = DVW'(r_gh) + DVW'(2);
    assign gw_s = CXW'(r_gw);
    assign gh_s = CYW'(r_gh);

    assign load_zero_fix = (r_load_pos >= r_total);

    // Next raster position of the padded frame walk.
    assign scan_go = r_pre || ((r_scan_lin + SPW'(1)) < r_frame);
    always_comb begin
        if (r_pre) begin
            nxt_sx = '0;
            nxt_sy = '0;
        end else if (DVW'(r_sx) == pw - DVW'(1)) begin
            nxt_sx = '0;
            nxt_sy = r_sy + PYW'(1);
        end else begin
            nxt_sx = r_sx + PXW'(1);
            nxt_sy = r_sy;
        end
    end
    assign sc_x = CXW'(nxt_sx) - CXW'(1);
    assign sc_y = CYW'(nxt_sy) - CYW'(1);

    // Neighbour under the current phase.
    assign nb_x = CXW'(r_cur_x) + CXW'(STEP_DX[r_phase]);
    assign nb_y = CYW'(r_cur_y) + CYW'(STEP_DY[r_phase]);

    // Qualify the probed coordinate held in r_px / r_py.
    assign pr_in_grid = !r_px[CXW-1] && !r_py[CYW-1] && (r_px < gw_s) && (r_py < gh_s);
    assign pr_in_mem  = !r_px[CXW-1] && !r_py[CYW-1] &&
                        (r_px < CXW'(MAX_WIDTH)) && (r_py < CYW'(MAX_HEIGHT));
    assign pr_start   = (r_px == CXW'(r_start_x)) && (r_py == CYW'(r_start_y));

    // One restoring division step per cycle.
    assign dv_trial    = {r_dv_rem, r_dv_num[DIVW-1]};
    assign dv_ge       = dv_trial >= {1'b0, r_dv_den};
    assign dv_rem_next = dv_ge ? DVW'(dv_trial - {1'b0, r_dv_den}) : DVW'(dv_trial);
    assign dv_q_next   = {r_dv_num[DIVW-2:0], dv_ge};

    assign rd_addr = (r_state == S_T_RD) ? {nb_y[YW-1:0], nb_x[XW-1:0]}
                                         : {sc_y[YW-1:0], sc_x[XW-1:0]};

    always_comb begin
        n_state = r_state;   n_rs = r_rs;       n_dirty = r_dirty;
        n_pend = r_pend;     n_clr = r_clr;
        n_scan_width = r_scan_width; n_scan_height = r_scan_height;
        n_downsample = r_downsample;
        n_gw = r_gw;         n_gh = r_gh;       n_total = r_total;  n_frame = r_frame;
        n_load_pos = r_load_pos; n_lx = r_lx;   n_ly = r_ly;
        n_bx = r_bx;         n_by = r_by;       n_subx = r_subx;    n_suby = r_suby;
        n_pre = r_pre;       n_scan_lin = r_scan_lin; n_sx = r_sx;  n_sy = r_sy;
        n_inside = r_inside; n_tracing = r_tracing;
        n_cur_x = r_cur_x;   n_cur_y = r_cur_y;
        n_start_x = r_start_x; n_start_y = r_start_y;
        n_phase = r_phase;   n_miss = r_miss;   n_px = r_px;        n_py = r_py;
        n_dv_num = r_dv_num; n_dv_rem = r_dv_rem; n_dv_den = r_dv_den; n_dv_cnt = r_dv_cnt;
        n_ov = r_ov && !i_out_ready;
        n_out = r_out;       n_res = r_res;
        cell_we = 1'b0;      cell_waddr = {r_by, r_bx}; cell_wdata = 1'b1;
        vis_we = 1'b0;       vis_waddr = {r_py[YW-1:0], r_px[XW-1:0]}; vis_wdata = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                // sweep both maps to zero
                cell_we = 1'b1;  cell_waddr = r_clr;  cell_wdata = 1'b0;
                vis_we  = 1'b1;  vis_waddr  = r_clr;  vis_wdata  = 1'b0;
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = r_pend ? S_LPIX : S_IDLE;
                end
            end
            S_LPIX: begin
                // first pixel of the image lands in cell (0,0)
                cell_we = 1'b1;
                cell_waddr = '0;
                n_pend = 1'b0;
                n_state = S_IDLE;
            end
            S_RSYNC: begin
                n_dv_rem = '0;
                n_dv_cnt = '0;
                n_state  = S_DIV;
                unique case (r_rs)
                    RS_GW: begin
                        n_dv_num = DIVW'(eff_w) + DIVW'(eff_d) - DIVW'(1);
                        n_dv_den = DVW'(eff_d);
                    end
                    RS_GH: begin
                        n_dv_num = DIVW'(eff_h) + DIVW'(eff_d) - DIVW'(1);
                        n_dv_den = DVW'(eff_d);
                    end
                    RS_MUL: begin
                        n_total = LPW'(eff_w) * LPW'(eff_h);
                        n_frame = SPW'(pw) * SPW'(ph);
                        n_rs    = RS_LOAD;
                        n_state = S_RSYNC;
                    end
                    RS_LOAD: begin
                        // a position beyond the image restarts the load
                        n_load_pos = load_zero_fix ? '0 : r_load_pos;
                        n_dv_num   = load_zero_fix ? '0 : DIVW'(r_load_pos);
                        n_dv_den   = DVW'(eff_w);
                    end
                    RS_BY: begin
                        n_dv_num = DIVW'(r_ly);
                        n_dv_den = DVW'(eff_d);
                    end
                    RS_BX: begin
                        n_dv_num = DIVW'(r_lx);
                        n_dv_den = DVW'(eff_d);
                    end
                    RS_SCAN: begin
                        n_dv_num = DIVW'(r_scan_lin);
                        n_dv_den = pw;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                n_dv_num = dv_q_next;
                n_dv_rem = dv_rem_next;
                n_dv_cnt = r_dv_cnt + DCW'(1);
                if (r_dv_cnt == DCW'(DIVW - 1)) begin
                    n_state = S_RSYNC;
                    unique case (r_rs)
                        RS_GW: begin
                            n_gw = GXW'(dv_q_next);
                            n_rs = RS_GH;
                        end
                        RS_GH: begin
                            n_gh = GYW'(dv_q_next);
                            n_rs = RS_MUL;
                        end
                        RS_LOAD: begin
                            n_ly = REG_W'(dv_q_next);
                            n_lx = REG_W'(dv_rem_next);
                            n_rs = RS_BY;
                        end
                        RS_BY: begin
                            n_by   = YW'(dv_q_next);
                            n_suby = SUB_W'(dv_rem_next);
                            n_rs   = RS_BX;
                        end
                        RS_BX: begin
                            n_bx   = XW'(dv_q_next);
                            n_subx = SUB_W'(dv_rem_next);
                            n_rs   = RS_SCAN;
                        end
                        default: begin
                            n_sy    = PYW'(dv_q_next);
                            n_sx    = PXW'(dv_rem_next);
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_IDLE: begin
                if (r_dirty) begin
                    n_dirty = 1'b0;
                    n_rs    = RS_GW;
                    n_state = S_RSYNC;
                end else if (acc_in && i_in_data.mode) begin
                    n_state = r_tracing ? S_T_RD : S_S_ADV;
                end else if (acc_in) begin
                    if (r_load_pos == '0) begin
                        // new image: clear maps, reset the walk, write pixel after
                        n_pend = i_in_data.pixel_on;
                        n_clr = '0;
                        n_state = S_CLEAR;
                        n_pre = 1'b1;  n_scan_lin = '0;  n_sx = '0;  n_sy = '0;
                        n_inside = 1'b0;  n_tracing = 1'b0;
                        n_cur_x = '0;  n_cur_y = '0;  n_start_x = '0;  n_start_y = '0;
                        n_phase = '0;  n_miss = '0;
                    end else begin
                        cell_we = i_in_data.pixel_on;
                    end
                    // advance the raster counters
                    if ((r_load_pos + LPW'(1)) >= r_total) begin
                        n_load_pos = '0;
                        n_lx = '0;  n_ly = '0;  n_bx = '0;  n_by = '0;
                        n_subx = '0;  n_suby = '0;
                    end else begin
                        n_load_pos = r_load_pos + LPW'(1);
                        if (r_lx == eff_w - REG_W'(1)) begin
                            n_lx = '0;  n_subx = '0;  n_bx = '0;
                            n_ly = r_ly + REG_W'(1);
                            if (SUB_W'(r_suby + SUB_W'(1)) == SUB_W'(eff_d) ||
                                (eff_d == DS_MAX && r_suby == '1)) begin
                                n_suby = '0;
                                n_by   = r_by + YW'(1);
                            end else begin
                                n_suby = r_suby + SUB_W'(1);
                            end
                        end else begin
                            n_lx = r_lx + REG_W'(1);
                            if (SUB_W'(r_subx + SUB_W'(1)) == SUB_W'(eff_d) ||
                                (eff_d == DS_MAX && r_subx == '1)) begin
                                n_subx = '0;
                                n_bx   = r_bx + XW'(1);
                            end else begin
                                n_subx = r_subx + SUB_W'(1);
                            end
                        end
                    end
                end
            end
            S_T_RD: begin
                n_px = nb_x;
                n_py = nb_y;
                n_state = S_T_EV;
            end
            S_T_EV: begin
                if (pr_in_grid && cell_q) begin
                    if (pr_start) begin
                        // back at the start: contour closed
                        n_tracing = 1'b0;
                        n_inside  = 1'b1;
                        n_state   = S_S_ADV;
                    end else begin
                        vis_we  = 1'b1;
                        n_cur_x = XW'(r_px);
                        n_cur_y = YW'(r_py);
                        n_phase = r_phase + PHASE_TURN;
                        n_miss  = '0;
                        n_res   = '{cell_x: 8'(r_px), cell_y: 8'(r_py),
                                    new_contour: 1'b0, finished: 1'b0};
                        n_state = S_PUT;
                    end
                end else begin
                    n_phase = r_phase + 3'd1;
                    n_miss  = r_miss + 4'd1;
                    if (r_miss == MISS_LIMIT) begin
                        // lone cell island
                        n_tracing = 1'b0;
                        n_state   = S_S_ADV;
                    end else begin
                        n_state = S_T_RD;
                    end
                end
            end
            S_S_ADV: begin
                if (scan_go) begin
                    n_pre      = 1'b0;
                    n_scan_lin = r_pre ? '0 : r_scan_lin + SPW'(1);
                    n_sx = nxt_sx;
                    n_sy = nxt_sy;
                    n_px = sc_x;
                    n_py = sc_y;
                    n_state = S_S_EV;
                end else begin
                    n_res   = '{cell_x: 8'd0, cell_y: 8'd0, new_contour: 1'b0, finished: 1'b1};
                    n_state = S_PUT;
                end
            end
            S_S_EV: begin
                n_state = S_S_ADV;
                if (r_inside) begin
                    if (!(pr_in_grid && cell_q)) begin
                        n_inside = 1'b0;
                    end
                end else if (pr_in_mem && vis_q) begin
                    n_inside = 1'b1;
                end else if (pr_in_grid && cell_q) begin
                    vis_we    = 1'b1;
                    n_start_x = XW'(r_px);
                    n_start_y = YW'(r_py);
                    n_cur_x   = XW'(r_px);
                    n_cur_y   = YW'(r_py);
                    n_phase   = '0;
                    n_miss    = '0;
                    n_tracing = 1'b1;
                    n_res     = '{cell_x: 8'(r_px), cell_y: 8'(r_py),
                                  new_contour: 1'b1, finished: 1'b0};
                    n_state   = S_PUT;
                end
            end
            S_PUT: begin
                // hold until the output register frees up
                if (!r_ov || i_out_ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (acc_cfg) begin
            n_dirty = 1'b1;
            unique case (i_cfg_index)
                CFG_SCAN_WIDTH:  n_scan_width  = i_cfg_data;
                CFG_SCAN_HEIGHT: n_scan_height = i_cfg_data;
                CFG_DOWNSAMPLE:  n_downsample  = DS_W'(i_cfg_data);
                default:         n_dirty       = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rs    <= RS_GW;
            r_dirty <= 1'b1;
            r_pend  <= 1'b0;
            r_clr   <= '0;
            r_scan_width  <= SCAN_DIM_RST;
            r_scan_height <= SCAN_DIM_RST;
            r_downsample  <= DS_RST;
            r_load_pos <= '0;
            r_lx <= '0;  r_ly <= '0;  r_bx <= '0;  r_by <= '0;
            r_subx <= '0;  r_suby <= '0;
            r_pre <= 1'b1;  r_scan_lin <= '0;  r_sx <= '0;  r_sy <= '0;
            r_inside <= 1'b0;  r_tracing <= 1'b0;
            r_cur_x <= '0;  r_cur_y <= '0;  r_start_x <= '0;  r_start_y <= '0;
            r_phase <= '0;  r_miss <= '0;
            r_dv_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;  r_rs <= n_rs;  r_dirty <= n_dirty;
            r_pend <= n_pend;    r_clr <= n_clr;
            r_scan_width <= n_scan_width;  r_scan_height <= n_scan_height;
            r_downsample <= n_downsample;
            r_load_pos <= n_load_pos;  r_lx <= n_lx;  r_ly <= n_ly;
            r_bx <= n_bx;  r_by <= n_by;  r_subx <= n_subx;  r_suby <= n_suby;
            r_pre <= n_pre;  r_scan_lin <= n_scan_lin;  r_sx <= n_sx;  r_sy <= n_sy;
            r_inside <= n_inside;  r_tracing <= n_tracing;
            r_cur_x <= n_cur_x;  r_cur_y <= n_cur_y;
            r_start_x <= n_start_x;  r_start_y <= n_start_y;
            r_phase <= n_phase;  r_miss <= n_miss;
            r_dv_cnt <= n_dv_cnt;
            r_ov <= n_ov;
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_gw <= n_gw;  r_gh <= n_gh;  r_total <= n_total;  r_frame <= n_frame;
        r_px <= n_px;  r_py <= n_py;
        r_dv_num <= n_dv_num;  r_dv_rem <= n_dv_rem;  r_dv_den <= n_dv_den;
        r_out <= n_out;  r_res <= n_res;
    end

    // A request beat goes straight into a probe or a scan step.
    `BBT_ASSERT_NEXT(a_req_dispatch, acc_in && i_in_data.mode, r_state == S_T_RD || r_state == S_S_ADV)
    // The first pixel of an image always starts the clearing pass.
    `BBT_ASSERT_NEXT(a_load_clear, acc_in && !i_in_data.mode && r_load_pos == '0, r_state == S_CLEAR)
    // A live trace never has more than the miss limit of empty probes.
    `BBT_ASSERT_IMP(a_miss_bound, r_tracing, r_miss <= MISS_LIMIT)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the bitmap boundary tracer: loads small images, asks for
// boundary cells and checks them against a built-in tracer model.
// Depends on bbt_pkg and the bitmap_boundary_tracer RTL.
`default_nettype none

module tb;
    import bbt_pkg::*;

    // Holds a model of the tracer plus the queue of boundary beats still owed.
    class TraceScoreboard;
        localparam int GRID_MAX = 256;
        localparam int PAD_W    = GRID_MAX + 2;

        logic [REG_W-1:0] width_reg  = SCAN_DIM_RST;
        logic [REG_W-1:0] height_reg = SCAN_DIM_RST;
        logic [DS_W-1:0]  ds_reg     = DS_RST;

        bit cells  [GRID_MAX*GRID_MAX];
        bit marked [PAD_W*PAD_W];
        int load_pos;
        int scan_pos = -1;
        bit in_ring, tracing;
        int cur_cell, start_cell;
        bit [2:0] phase;
        int misses;

        t_out_item owed [$];
        int  mismatches;
        bit  saw_finished;

        function int eff_w();
            return (width_reg == 0) ? 1 : (width_reg > GRID_MAX ? GRID_MAX : width_reg);
        endfunction

        function int eff_h();
            return (height_reg == 0) ? 1 : (height_reg > GRID_MAX ? GRID_MAX : height_reg);
        endfunction

        function int eff_ds();
            return (ds_reg == 0) ? 1 : (ds_reg > DS_MAX ? DS_MAX : ds_reg);
        endfunction

        function int grid_w();
            return (eff_w() + eff_ds() - 1) / eff_ds();
        endfunction

        function int grid_h();
            return (eff_h() + eff_ds() - 1) / eff_ds();
        endfunction

        function bit filled(int x, int y);
            if (x < 0 || y < 0 || x >= grid_w() || y >= grid_h())
                return 0;
            return cells[y*GRID_MAX + x];
        endfunction

        function int mark_idx(int x, int y);
            return (y + 1) * PAD_W + (x + 1);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
            case (idx)
                CFG_SCAN_WIDTH:  width_reg  = val;
                CFG_SCAN_HEIGHT: height_reg = val;
                CFG_DOWNSAMPLE:  ds_reg     = val[DS_W-1:0];
                default: ;
            endcase
        endfunction

        function void load_pixel(bit on);
            int total;
            int w;
            int d;
            w = eff_w();
            d = eff_ds();
            total = w * eff_h();
            if (load_pos >= total) load_pos = 0;
            // First pixel of an image: wipe both maps and the walk.
            if (load_pos == 0) begin
                foreach (cells[i]) cells[i] = 0;
                foreach (marked[i]) marked[i] = 0;
                scan_pos = -1;
                in_ring = 0;
                tracing = 0;
                cur_cell = 0;
                start_cell = 0;
                phase = 0;
                misses = 0;
            end
            if (on)
                cells[((load_pos / w) / d) * GRID_MAX + (load_pos % w) / d] = 1;
            load_pos++;
            if (load_pos >= total) load_pos = 0;
        endfunction

        function t_out_item next_boundary();
            t_out_item res;
            int cx, cy, x, y, pw, frame, idx;
            res = '0;
            if (tracing) begin
                forever begin
                    cx = cur_cell % GRID_MAX + STEP_DX[phase];
                    cy = cur_cell / GRID_MAX + STEP_DY[phase];
                    if (filled(cx, cy)) begin
                        idx = cy * GRID_MAX + cx;
                        if (idx == start_cell) begin
                            // contour closed: resume the walk inside it
                            tracing = 0;
                            in_ring = 1;
                            break;
                        end
                        marked[mark_idx(cx, cy)] = 1;
                        cur_cell = idx;
                        phase = phase + PHASE_TURN;
                        misses = 0;
                        res.cell_x = 8'(cx);
                        res.cell_y = 8'(cy);
                        return res;
                    end
                    phase = phase + 3'd1;
                    misses++;
                    // lone cell: nine empty probes in a row
                    if (misses > MISS_LIMIT) begin
                        tracing = 0;
                        break;
                    end
                end
            end
            pw = grid_w() + 2;
            frame = pw * (grid_h() + 2);
            while (scan_pos + 1 < frame) begin
                scan_pos++;
                x = scan_pos % pw - 1;
                y = scan_pos / pw - 1;
                if (in_ring) begin
                    if (!filled(x, y)) in_ring = 0;
                end else if (marked[mark_idx(x, y)]) begin
                    in_ring = 1;
                end else if (filled(x, y)) begin
                    marked[mark_idx(x, y)] = 1;
                    start_cell = y * GRID_MAX + x;
                    cur_cell = start_cell;
                    phase = 0;
                    misses = 0;
                    tracing = 1;
                    res.cell_x = 8'(x);
                    res.cell_y = 8'(y);
                    res.new_contour = 1;
                    return res;
                end
            end
            res.finished = 1;
            saw_finished = 1;
            return res;
        endfunction

        function void note_input(t_in_item it);
            if (it.mode == 1'b0)
                load_pixel(it.pixel_on);
            else
                owed.push_back(next_boundary());
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_item;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: x=%0d y=%0d new=%0b fin=%0b",
                             got.cell_x, got.cell_y, got.new_contour, got.finished);
                return;
            end
            exp_item = owed.pop_front();
            if (got !== exp_item) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected x=%0d y=%0d new=%0b fin=%0b",
                             exp_item.cell_x, exp_item.cell_y, exp_item.new_contour,
                             exp_item.finished);
                    $display("          got      x=%0d y=%0d new=%0b fin=%0b",
                             got.cell_x, got.cell_y, got.new_contour, got.finished);
                end
            end
        endfunction
    endclass

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;
    localparam int   STALL_LIMIT  = 300000;  // clearing pass plus recompute, several times over
    localparam int   SETTLE_CYC   = 200;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       in_valid = 0;
    t_in_item   in_data = '0;
    logic       out_ready = 0;
    logic       cfg_valid = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;
    logic       in_ready, out_valid, cfg_ready;
    t_out_item  out_data;

    TraceScoreboard sb = new();
    bit burst;       // no idling on either side while set
    int hold_left;
    int idle_cycles;

    bitmap_boundary_tracer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Stall the result side at random.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= 1;
            if (!burst && $urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    // Check every result beat against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog: end the run after too long without any beat.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one beat; valid stays high into the next beat when no gap follows.
    task automatic send_beat(logic mode, logic pix);
        int gap;
        t_in_item it;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        it.mode = mode;
        it.pixel_on = pix;
        in_valid <= 1;
        in_data <= it;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(it);
    endtask

    // Write one register, then drop valid.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed beat has come back.
    task automatic drain();
        in_valid <= 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Ask for boundary cells until the walk reports finished, then a few more.
    task automatic trace_all();
        int n;
        sb.saw_finished = 0;
        n = 0;
        while (!sb.saw_finished && n < 300) begin
            send_beat(MODE_ADVANCE, 1'($urandom_range(0, 1)));
            n++;
        end
        repeat ($urandom_range(1, 3)) send_beat(MODE_ADVANCE, 1'($urandom_range(0, 1)));
    endtask

    // Write all registers, load count pixels (-1: the whole image) at the
    // given fill percentage with some requests mixed in, then trace.
    task automatic run_image(int w, int h, int ds, int count, int fill, int noise);
        int total;
        drain();
        burst = ($urandom_range(0, 3) == 0);
        write_reg(CFG_SCAN_WIDTH, REG_W'(w));
        write_reg(CFG_SCAN_HEIGHT, REG_W'(h));
        write_reg(CFG_DOWNSAMPLE, REG_W'(ds));
        total = (count < 0) ? sb.eff_w() * sb.eff_h() : count;
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < noise)
                send_beat(MODE_ADVANCE, 1'($urandom_range(0, 1)));
            send_beat(MODE_LOAD, $urandom_range(0, 99) < fill);
        end
        trace_all();
    endtask

    initial begin
        logic [19:0] pattern;
        hold_left = 0;
        idle_cycles = 0;
        burst = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed image: a ring around a hole, a lone cell, an empty row.
        pattern = 20'b00000_00111_10101_00111;
        write_reg(CFG_SCAN_WIDTH, REG_W'(5));
        write_reg(CFG_SCAN_HEIGHT, REG_W'(4));
        write_reg(CFG_DOWNSAMPLE, REG_W'(1));
        send_beat(MODE_ADVANCE, 1'b1);
        for (int i = 0; i < 20; i++) send_beat(MODE_LOAD, pattern[i]);
        trace_all();

        // Change the grid after a load without loading again.
        drain();
        write_reg(CFG_DOWNSAMPLE, REG_W'(2));
        trace_all();

        // Zero registers clamp to a one-pixel image.
        run_image(0, 0, 0, -1, 100, 0);
        // Widest single row, tallest single column, oversized values clamp.
        run_image(511, 1, 1, -1, 50, 5);
        run_image(1, 511, 15, -1, 40, 5);
        // Largest image, partly loaded; the next change restarts the load if the position lies beyond the new image.
        run_image(256, 256, 8, 200, 30, 2);

        for (int p = 0; p < 4; p++)
            run_image($urandom_range(1, 16), $urandom_range(1, 16),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8)
                                                  : $urandom_range(1, 4),
                      -1, $urandom_range(10, 75), ($urandom_range(0, 2) == 0) ? 10 : 0);

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
